// ===== rtl/plds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plds_pkg : shared types and constants of the point/line distance sorter
// Sizes of the sorting chain, configuration register indices and the
// structures passed between the key unit, the chain cells and the top level.
// ----------------------------------------------------------------------------
package plds_pkg;

    // Number of cells in the sorting chain.
    localparam int MAX_POINTS = 64;
    // Counter width: holds 0 .. MAX_POINTS inclusive.
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int COORD_W    = 16;
    localparam int COEF_W     = 16;
    localparam int CONST_W    = 32;
    localparam int NORM_W     = 24;
    localparam int KEY_W      = 33;
    localparam int DIST_W     = 40;
    localparam int DIST_SHIFT = 16;
    localparam int PROD_W     = 2 * COEF_W;
    localparam int SUM_W      = CONST_W + 2;
    localparam int MUL_W      = KEY_W + NORM_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_NORM = 2'd3;

    // One stored point: its key and its coordinates.
    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } entry_t;

    // A point entering the key unit.
    typedef struct packed {
        logic                      valid;
        logic                      store;
        logic                      last;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    // A point leaving the key unit with its key formed.
    typedef struct packed {
        logic   valid;
        logic   store;
        logic   last;
        entry_t entry;
    } item_t;

    // Control broadcast to every chain cell.
    typedef struct packed {
        logic ins;
        logic pop;
    } chain_ctrl_t;

endpackage

// ===== rtl/point_line_distance_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_line_distance_sorter : sorts a set of points by distance to a line
// Points arrive one per beat; the last one closes the set, after which every
// stored point leaves in ascending order of |A*x+B*y+C|, with its distance.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake           Payload
//  -------  ------------------  ------------------------------------------------
//  in       in_valid/in_ready   x_coord, y_coord, last_point
//  out      out_valid/out_ready x_out, y_out, distance, last_result, overflowed
//  cfg      cfg_wr_en           cfg_index, cfg_data (no handshake back)
//
// While loading, one point is accepted per cycle. Each point passes through
// the key pipeline stages and is then inserted into the chain of sorting
// cells. Once the last point of a set is accepted the input stalls; draining
// starts when that point leaves the key pipeline and delivers one result per
// cycle while the output is taken. A stalled output simply holds the chain.
// Reset is asynchronous and active low; it empties the chain (the fill count
// returns to zero) and clears all configuration registers.
//
// The chain is a row of identical cells ordered by key, smallest at cell 0.
// A new point is broadcast to all cells: each cell reports whether its own
// point is larger (or whether it is empty), and the cell at the boundary takes
// the new point while every cell behind it takes its left neighbour's. Equal
// keys therefore keep arrival order. Draining shifts the whole row towards
// cell 0, and the output register takes cell 0 together with its distance,
// key times inv_norm, truncated to eight fractional bits.
// Points beyond the chain's capacity are dropped, and every result of that
// set carries the overflowed flag.
// ----------------------------------------------------------------------------
module point_line_distance_sorter (
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    cfg_wr_en,
    input  logic [plds_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [plds_pkg::CFG_DATA_W-1:0]         cfg_data,

    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [plds_pkg::COORD_W-1:0]     x_coord,
    input  logic signed [plds_pkg::COORD_W-1:0]     y_coord,
    input  logic                                    last_point,

    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [plds_pkg::COORD_W-1:0]     x_out,
    output logic signed [plds_pkg::COORD_W-1:0]     y_out,
    output logic [plds_pkg::DIST_W-1:0]             distance,
    output logic                                    last_result,
    output logic                                    overflowed
);

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    // Configuration registers.
    logic signed [plds_pkg::COEF_W-1:0]  coef_a_reg;
    logic signed [plds_pkg::COEF_W-1:0]  coef_b_reg;
    logic signed [plds_pkg::CONST_W-1:0] coef_c_reg;
    logic [plds_pkg::NORM_W-1:0]         inv_norm_reg;

    // Control.
    state_t                              state_reg;
    state_t                              state_next;
    logic                                closing_reg;
    logic                                closing_next;
    logic [plds_pkg::CNT_W-1:0]          acc_cnt_reg;
    logic [plds_pkg::CNT_W-1:0]          acc_cnt_next;
    logic [plds_pkg::CNT_W-1:0]          fill_reg;
    logic [plds_pkg::CNT_W-1:0]          fill_next;
    logic                                drop_reg;
    logic                                drop_next;

    logic                                in_fire;
    logic                                full;
    logic                                pop;
    logic                                set_done;
    plds_pkg::point_t                    point;
    plds_pkg::item_t                     item;
    plds_pkg::chain_ctrl_t               ctrl;

    // Chain wiring.
    plds_pkg::entry_t                    cell_entry [plds_pkg::MAX_POINTS];
    logic [plds_pkg::MAX_POINTS-1:0]     cell_take;
    logic [plds_pkg::MAX_POINTS-1:0]     cell_occ;

    // Output register.
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic signed [plds_pkg::COORD_W-1:0] x_out_reg;
    logic signed [plds_pkg::COORD_W-1:0] y_out_reg;
    logic [plds_pkg::DIST_W-1:0]         dist_reg;
    logic                                last_out_reg;
    logic                                ovf_out_reg;
    logic [plds_pkg::MUL_W-1:0]          dist_prod;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg   <= '0;
            coef_b_reg   <= '0;
            coef_c_reg   <= '0;
            inv_norm_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                plds_pkg::REG_COEF_A:   coef_a_reg   <= cfg_data[plds_pkg::COEF_W-1:0];
                plds_pkg::REG_COEF_B:   coef_b_reg   <= cfg_data[plds_pkg::COEF_W-1:0];
                plds_pkg::REG_COEF_C:   coef_c_reg   <= cfg_data[plds_pkg::CONST_W-1:0];
                plds_pkg::REG_INV_NORM: inv_norm_reg <= cfg_data[plds_pkg::NORM_W-1:0];
                default:                ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input side: the input stalls from the last point of a set until the
    // set has been fully drained.
    // ------------------------------------------------------------------
    assign in_ready = !closing_reg;
    assign in_fire  = in_valid && in_ready;
    assign full     = (acc_cnt_reg == plds_pkg::CNT_W'(plds_pkg::MAX_POINTS));

    assign point.valid = in_fire;
    assign point.store = !full;
    assign point.last  = last_point;
    assign point.x     = x_coord;
    assign point.y     = y_coord;

    plds_key_unit u_key (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point),
        .coef_a (coef_a_reg),
        .coef_b (coef_b_reg),
        .coef_c (coef_c_reg),
        .item   (item)
    );

    // ------------------------------------------------------------------
    // Sequencing.
    // ------------------------------------------------------------------
    assign pop      = (state_reg == ST_DRAIN) && (!out_valid_reg || out_ready);
    assign set_done = pop && (fill_reg == plds_pkg::CNT_W'(1));

    assign ctrl.ins = item.valid && item.store;
    assign ctrl.pop = pop;

    always_comb
    begin
        state_next   = state_reg;
        closing_next = closing_reg;
        acc_cnt_next = acc_cnt_reg;
        fill_next    = fill_reg;
        drop_next    = drop_reg;

        if (in_fire)
        begin
            if (full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                acc_cnt_next = acc_cnt_reg + plds_pkg::CNT_W'(1);
            end
            if (last_point)
            begin
                closing_next = 1'b1;
            end
        end

        if (ctrl.ins)
        begin
            fill_next = fill_reg + plds_pkg::CNT_W'(1);
        end
        else if (pop)
        begin
            fill_next = fill_reg - plds_pkg::CNT_W'(1);
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (item.valid && item.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (set_done)
                begin
                    state_next   = ST_LOAD;
                    closing_next = 1'b0;
                    acc_cnt_next = '0;
                    drop_next    = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            closing_reg <= 1'b0;
            acc_cnt_reg <= '0;
            fill_reg    <= '0;
            drop_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            closing_reg <= closing_next;
            acc_cnt_reg <= acc_cnt_next;
            fill_reg    <= fill_next;
            drop_reg    <= drop_next;
        end
    end

    // ------------------------------------------------------------------
    // Sorting chain. Occupied cells always form a prefix of the row, so
    // the fill count tells each cell whether it holds a point.
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < plds_pkg::MAX_POINTS; gi++)
        begin : g_cell
            plds_pkg::entry_t prev_entry;
            plds_pkg::entry_t next_entry;
            logic             prev_take;

            assign cell_occ[gi] = (plds_pkg::CNT_W'(gi) < fill_reg);

            if (gi == 0)
            begin : g_head
                assign prev_take  = 1'b0;
                assign prev_entry = '0;
            end
            else
            begin : g_body
                assign prev_take  = cell_take[gi-1];
                assign prev_entry = cell_entry[gi-1];
            end

            if (gi == plds_pkg::MAX_POINTS - 1)
            begin : g_tail
                assign next_entry = '0;
            end
            else
            begin : g_inner
                assign next_entry = cell_entry[gi+1];
            end

            plds_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .new_entry  (item.entry),
                .occupied   (cell_occ[gi]),
                .prev_take  (prev_take),
                .prev_entry (prev_entry),
                .next_entry (next_entry),
                .take       (cell_take[gi]),
                .entry      (cell_entry[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output register: takes cell 0 on each pop, with its distance.
    // ------------------------------------------------------------------
    assign dist_prod = plds_pkg::MUL_W'(cell_entry[0].key)
                     * plds_pkg::MUL_W'(inv_norm_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            x_out_reg    <= cell_entry[0].x;
            y_out_reg    <= cell_entry[0].y;
            dist_reg     <= dist_prod[plds_pkg::DIST_SHIFT +: plds_pkg::DIST_W];
            last_out_reg <= (fill_reg == plds_pkg::CNT_W'(1));
            ovf_out_reg  <= drop_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign x_out       = x_out_reg;
    assign y_out       = y_out_reg;
    assign distance    = dist_reg;
    assign last_result = last_out_reg;
    assign overflowed  = ovf_out_reg;

endmodule

// ===== rtl/plds_key_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plds_key_unit : two-stage key pipeline
// Forms |A*x + B*y + C| for each point: products in the first stage, sum and
// magnitude in the second.
// ----------------------------------------------------------------------------
module plds_key_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  plds_pkg::point_t                       point,
    input  logic signed [plds_pkg::COEF_W-1:0]     coef_a,
    input  logic signed [plds_pkg::COEF_W-1:0]     coef_b,
    input  logic signed [plds_pkg::CONST_W-1:0]    coef_c,
    output plds_pkg::item_t                        item
);

    logic                                   s1_valid_reg;
    logic                                   s1_store_reg;
    logic                                   s1_last_reg;
    logic signed [plds_pkg::COORD_W-1:0]    s1_x_reg;
    logic signed [plds_pkg::COORD_W-1:0]    s1_y_reg;
    logic signed [plds_pkg::PROD_W-1:0]     s1_pa_reg;
    logic signed [plds_pkg::PROD_W-1:0]     s1_pb_reg;
    logic signed [plds_pkg::CONST_W-1:0]    s1_c_reg;

    logic signed [plds_pkg::SUM_W-1:0]      sum;
    logic        [plds_pkg::SUM_W-1:0]      mag;

    logic                                   s2_valid_reg;
    logic                                   s2_store_reg;
    logic                                   s2_last_reg;
    plds_pkg::entry_t                       s2_entry_reg;
    plds_pkg::entry_t                       s2_entry_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= point.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_store_reg <= point.store;
        s1_last_reg  <= point.last;
        s1_x_reg     <= point.x;
        s1_y_reg     <= point.y;
        s1_pa_reg    <= coef_a * point.x;
        s1_pb_reg    <= coef_b * point.y;
        s1_c_reg     <= coef_c;
        s2_store_reg <= s1_store_reg;
        s2_last_reg  <= s1_last_reg;
        s2_entry_reg <= s2_entry_next;
    end

    // The sum never exceeds 2^32 in magnitude, so 34 signed bits hold it.
    always_comb
    begin
        sum = plds_pkg::SUM_W'(s1_pa_reg) + plds_pkg::SUM_W'(s1_pb_reg)
            + plds_pkg::SUM_W'(s1_c_reg);
        mag = sum[plds_pkg::SUM_W-1] ? plds_pkg::SUM_W'(-sum) : plds_pkg::SUM_W'(sum);
        s2_entry_next.key = mag[plds_pkg::KEY_W-1:0];
        s2_entry_next.x   = s1_x_reg;
        s2_entry_next.y   = s1_y_reg;
    end

    assign item.valid = s2_valid_reg;
    assign item.store = s2_store_reg;
    assign item.last  = s2_last_reg;
    assign item.entry = s2_entry_reg;

endmodule

// ===== rtl/plds_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plds_cell : one cell of the sorting chain
// Holds one point. On insertion it keeps its point, takes the new one or takes
// its left neighbour's; on a pop it takes its right neighbour's point.
// ----------------------------------------------------------------------------
module plds_cell (
    input  logic                  clk,
    input  plds_pkg::chain_ctrl_t ctrl,
    input  plds_pkg::entry_t      new_entry,
    input  logic                  occupied,
    input  logic                  prev_take,
    input  plds_pkg::entry_t      prev_entry,
    input  plds_pkg::entry_t      next_entry,
    output logic                  take,
    output plds_pkg::entry_t      entry
);

    plds_pkg::entry_t entry_reg;
    plds_pkg::entry_t entry_next;

    // Strictly greater, so that a new point goes behind equal keys.
    assign take = !occupied || (entry_reg.key > new_entry.key);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.pop)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.ins)
        begin
            if (prev_take)
            begin
                entry_next = prev_entry;
            end
            else if (take)
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
